// ===== sv/chwh_pkg.sv =====
package chwh_pkg;

    // sizes of the stores
    localparam int NUM_BINS   = 1024;
    localparam int NUM_EVENTS = 65536;

    localparam int MAP_AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int BIN_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // field widths
    localparam int ACTION_W = 3;
    localparam int EVENT_W  = 16;
    localparam int BIN_W    = 10;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 63;
    localparam int PROD_W   = 2 * WEIGHT_W;
    localparam int FRAC_W   = 16;
    localparam int ENTRY_W  = SUM_W + SQ_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;

    // configuration registers
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_LOWER_CLAMP = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_UPPER_CLAMP = 1'd1;
    localparam logic signed [WEIGHT_W-1:0] LOWER_RESET = 32'sh8000_0000;
    localparam logic signed [WEIGHT_W-1:0] UPPER_RESET = 32'sh7FFF_FFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_MAP    = 3'd0,
        ACT_START  = 3'd1,
        ACT_ADD    = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_ACC,
        S_READ
    } t_state;

    typedef struct packed {
        logic map_wr;
        logic add_load;
        logic rd_in;
        logic rd_map;
        logic acc_wr;
        logic clr_start;
        logic clr_wr;
        logic pass_set;
        logic pass_clr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

endpackage

// ===== sv/clamped_weighted_histogram_core.sv =====
// clamped weighted histogram: events are mapped to bins, each weight is clamped to the
// lower then upper bound and added, with its square (q16.16, truncated), into its bin's
// saturating sums. one word is handled at a time. map, finish and any unknown action are
// done as the word is taken; add weight steps through map lookup, bin read with the square
// multiplier and saturating write-back into the bin memory; read bin reads the bin as the
// word is taken, then loads the output register, waiting only if the previous result still
// sits there. start pass runs a clearing sweep over the bin memory, one bin a cycle, so it
// holds s_axis_tready low for the whole sweep after the word is taken; the same sweep
// follows reset. the clamp registers may be written whenever no word is in flight
module clamped_weighted_histogram_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // input words
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [2:0] action, [18:3] event_index, [28:19] bin_index, [60:29] weight, [63:61] zero
    input  logic [chwh_pkg::IN_DATA_W-1:0]         s_axis_tdata,

    // result words
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [47:0] bin_sum, [110:48] bin_sum_squares, [111] sums_ready
    output logic [chwh_pkg::OUT_DATA_W-1:0]        m_axis_tdata,

    // clamp registers: 0 lower_clamp, 1 upper_clamp
    input  logic                                   i_cfg_we,
    input  logic [chwh_pkg::CFG_IW-1:0]            i_cfg_index,
    input  logic [chwh_pkg::WEIGHT_W-1:0]          i_cfg_data
);

    chwh_pkg::t_cmd    cmd;
    chwh_pkg::t_status status;

    logic [chwh_pkg::ACTION_W-1:0]         in_action;
    logic [chwh_pkg::EVENT_W-1:0]          in_event;
    logic [chwh_pkg::BIN_W-1:0]            in_bin;
    logic signed [chwh_pkg::WEIGHT_W-1:0]  in_weight;
    logic [chwh_pkg::SUM_W-1:0]            out_sum;
    logic [chwh_pkg::SQ_W-1:0]             out_sq;
    logic                                  out_ready_flag;

    // unpack the input word
    assign in_action = s_axis_tdata[2:0];
    assign in_event  = s_axis_tdata[18:3];
    assign in_bin    = s_axis_tdata[28:19];
    assign in_weight = s_axis_tdata[60:29];

    // sequencer: one word at a time, clearing sweep and read hand-off
    chwh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (in_action),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // map memory, bin memory, clamp, square and saturating adders
    chwh_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_event_index     (in_event),
        .i_bin_index       (in_bin),
        .i_weight          (in_weight),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_bin_sum         (out_sum),
        .o_bin_sum_squares (out_sq),
        .o_sums_ready      (out_ready_flag)
    );

    // pack the result word
    assign m_axis_tdata = {out_ready_flag, out_sq, out_sum};

endmodule

// ===== sv/chwh_ctrl.sv =====
module chwh_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [chwh_pkg::ACTION_W-1:0]  i_action,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  chwh_pkg::t_status              i_status,
    output chwh_pkg::t_cmd                 o_cmd
);

    chwh_pkg::t_state  r_state;
    chwh_pkg::t_state  n_state;
    chwh_pkg::t_action action;
    logic              accept;
    logic              slot_free;
    logic              r_out_valid;
    logic              n_out_valid;

    assign action    = chwh_pkg::t_action'(i_action);
    assign accept    = i_in_valid && (r_state == chwh_pkg::S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chwh_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            chwh_pkg::S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = chwh_pkg::S_IDLE;
                end
            end
            chwh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (action)
                        chwh_pkg::ACT_START: n_state = chwh_pkg::S_CLEAR;
                        chwh_pkg::ACT_ADD:   n_state = chwh_pkg::S_MAP;
                        chwh_pkg::ACT_READ:  n_state = chwh_pkg::S_READ;
                        default:             n_state = chwh_pkg::S_IDLE;
                    endcase
                end
            end
            chwh_pkg::S_MAP: n_state = chwh_pkg::S_ACC;
            chwh_pkg::S_ACC: n_state = chwh_pkg::S_IDLE;
            chwh_pkg::S_READ: begin
                if (slot_free) begin
                    n_state = chwh_pkg::S_IDLE;
                end
            end
            default: n_state = chwh_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_in_ready      = (r_state == chwh_pkg::S_IDLE);
        o_cmd.map_wr    = accept && (action == chwh_pkg::ACT_MAP);
        o_cmd.clr_start = accept && (action == chwh_pkg::ACT_START);
        o_cmd.pass_clr  = accept && (action == chwh_pkg::ACT_START);
        o_cmd.add_load  = accept && (action == chwh_pkg::ACT_ADD);
        o_cmd.pass_set  = accept && (action == chwh_pkg::ACT_FINISH);
        o_cmd.rd_in     = accept && (action == chwh_pkg::ACT_READ);
        o_cmd.rd_map    = (r_state == chwh_pkg::S_MAP);
        o_cmd.acc_wr    = (r_state == chwh_pkg::S_ACC);
        o_cmd.clr_wr    = (r_state == chwh_pkg::S_CLEAR);
        o_cmd.out_load  = (r_state == chwh_pkg::S_READ) && slot_free;
        n_out_valid     = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    a_add_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && action == chwh_pkg::ACT_ADD) |=> (r_state == chwh_pkg::S_MAP))
        else $error("add word did not enter map lookup");

    a_map_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chwh_pkg::S_MAP) |=> (r_state == chwh_pkg::S_ACC))
        else $error("map lookup not followed by accumulate");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && action == chwh_pkg::ACT_START) |=> (r_state == chwh_pkg::S_CLEAR))
        else $error("start did not begin clearing sweep");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("read result lost");

endmodule

// ===== sv/chwh_dp.sv =====
module chwh_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  chwh_pkg::t_cmd                        i_cmd,
    output chwh_pkg::t_status                     o_status,
    input  logic [chwh_pkg::EVENT_W-1:0]          i_event_index,
    input  logic [chwh_pkg::BIN_W-1:0]            i_bin_index,
    input  logic signed [chwh_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic                                  i_cfg_we,
    input  logic [chwh_pkg::CFG_IW-1:0]           i_cfg_index,
    input  logic [chwh_pkg::WEIGHT_W-1:0]         i_cfg_data,
    output logic [chwh_pkg::SUM_W-1:0]            o_bin_sum,
    output logic [chwh_pkg::SQ_W-1:0]             o_bin_sum_squares,
    output logic                                  o_sums_ready
);

    logic signed [chwh_pkg::WEIGHT_W-1:0] r_lower;
    logic signed [chwh_pkg::WEIGHT_W-1:0] r_upper;
    logic                                 r_pass_done;
    logic [chwh_pkg::BIN_AW-1:0]          r_clr_addr;

    logic [chwh_pkg::BIN_AW-1:0]  r_map_mem [chwh_pkg::NUM_EVENTS];
    logic [chwh_pkg::ENTRY_W-1:0] r_bin_mem [chwh_pkg::NUM_BINS];

    logic [chwh_pkg::BIN_AW-1:0]          r_map_q;
    logic [chwh_pkg::ENTRY_W-1:0]         r_bin_q;
    logic signed [chwh_pkg::WEIGHT_W-1:0] r_w;
    logic                                 r_add_ok;
    logic                                 r_rd_ok;
    logic signed [chwh_pkg::PROD_W-1:0]   r_prod;

    logic [chwh_pkg::SUM_W-1:0]           r_out_sum;
    logic [chwh_pkg::SQ_W-1:0]            r_out_sq;
    logic                                 r_out_ready;

    logic                                 ev_ok;
    logic                                 bin_ok;
    logic signed [chwh_pkg::WEIGHT_W-1:0] w_lo;
    logic signed [chwh_pkg::WEIGHT_W-1:0] w_clamped;
    logic [chwh_pkg::SUM_W-1:0]           cur_sum;
    logic [chwh_pkg::SQ_W-1:0]            cur_sq;
    logic signed [chwh_pkg::SUM_W:0]      sum_ext;
    logic [chwh_pkg::SQ_W:0]              sq_ext;
    logic [chwh_pkg::SUM_W-1:0]           sum_new;
    logic [chwh_pkg::SQ_W-1:0]            sq_new;
    logic                                 bin_we;
    logic [chwh_pkg::BIN_AW-1:0]          bin_waddr;
    logic [chwh_pkg::ENTRY_W-1:0]         bin_wdata;
    logic                                 bin_re;
    logic [chwh_pkg::BIN_AW-1:0]          bin_raddr;

    assign ev_ok  = 32'(i_event_index) < 32'(chwh_pkg::NUM_EVENTS);
    assign bin_ok = 32'(i_bin_index) < 32'(chwh_pkg::NUM_BINS);

    // lower bound first, upper bound wins when the bounds cross
    assign w_lo      = (i_weight < r_lower) ? r_lower : i_weight;
    assign w_clamped = (w_lo > r_upper) ? r_upper : w_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= chwh_pkg::LOWER_RESET;
            r_upper <= chwh_pkg::UPPER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                chwh_pkg::CFG_LOWER_CLAMP: r_lower <= i_cfg_data;
                chwh_pkg::CFG_UPPER_CLAMP: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_done <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cmd.pass_clr) begin
                r_pass_done <= 1'b0;
            end else if (i_cmd.pass_set) begin
                r_pass_done <= 1'b1;
            end
            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_status.clr_last = (r_clr_addr == chwh_pkg::BIN_AW'(chwh_pkg::NUM_BINS - 1));

    // event to bin map
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr && ev_ok && bin_ok) begin
            r_map_mem[i_event_index[chwh_pkg::MAP_AW-1:0]] <= i_bin_index[chwh_pkg::BIN_AW-1:0];
        end
        if (i_cmd.add_load) begin
            r_map_q <= r_map_mem[i_event_index[chwh_pkg::MAP_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_load) begin
            r_w      <= w_clamped;
            r_add_ok <= ev_ok;
        end
        if (i_cmd.rd_in) begin
            r_rd_ok <= bin_ok;
        end
        if (i_cmd.rd_map) begin
            r_prod <= r_w * r_w;
        end
    end

    assign cur_sum = r_bin_q[chwh_pkg::SUM_W-1:0];
    assign cur_sq  = r_bin_q[chwh_pkg::ENTRY_W-1:chwh_pkg::SUM_W];

    assign sum_ext = (chwh_pkg::SUM_W + 1)'($signed(cur_sum))
                   + (chwh_pkg::SUM_W + 1)'(r_w);
    assign sq_ext  = {1'b0, cur_sq}
                   + (chwh_pkg::SQ_W + 1)'(r_prod[chwh_pkg::PROD_W-1:chwh_pkg::FRAC_W]);

    always_comb begin
        if (sum_ext[chwh_pkg::SUM_W] != sum_ext[chwh_pkg::SUM_W-1]) begin
            sum_new = {sum_ext[chwh_pkg::SUM_W], {(chwh_pkg::SUM_W - 1){!sum_ext[chwh_pkg::SUM_W]}}};
        end else begin
            sum_new = sum_ext[chwh_pkg::SUM_W-1:0];
        end
        if (sq_ext[chwh_pkg::SQ_W]) begin
            sq_new = '1;
        end else begin
            sq_new = sq_ext[chwh_pkg::SQ_W-1:0];
        end
    end

    assign bin_we    = i_cmd.clr_wr || (i_cmd.acc_wr && r_add_ok);
    assign bin_waddr = i_cmd.clr_wr ? r_clr_addr : r_map_q;
    assign bin_wdata = i_cmd.clr_wr ? '0 : {sq_new, sum_new};
    assign bin_re    = i_cmd.rd_in || i_cmd.rd_map;
    assign bin_raddr = i_cmd.rd_map ? r_map_q : i_bin_index[chwh_pkg::BIN_AW-1:0];

    // per-bin sums, sum in the low bits
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bin_mem[bin_waddr] <= bin_wdata;
        end
        if (bin_re) begin
            r_bin_q <= r_bin_mem[bin_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sum   <= r_rd_ok ? cur_sum : '0;
            r_out_sq    <= r_rd_ok ? cur_sq : '0;
            r_out_ready <= r_pass_done;
        end
    end

    assign o_bin_sum         = r_out_sum;
    assign o_bin_sum_squares = r_out_sq;
    assign o_sums_ready      = r_out_ready;

endmodule

// ===== tb/bin_sums_checker.sv =====
module bin_sums_checker
    import chwh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    // [2:0] action, [18:3] event_index, [28:19] bin_index, [60:29] weight, [63:61] zero
    input  logic [IN_DATA_W-1:0]   i_in_data,

    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // [47:0] bin_sum, [110:48] bin_sum_squares, [111] sums_ready
    input  logic [OUT_DATA_W-1:0]  i_out_data,

    input  logic                   i_cfg_we,
    input  logic [CFG_IW-1:0]      i_cfg_index,
    input  logic [WEIGHT_W-1:0]    i_cfg_data,

    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam u64_t   SQ_MAX  = (u64_t'(1) << SQ_W) - 1;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sum_sq;
        logic                    ready;
    } bin_readout_t;

    bin_readout_t              readout_q[$];

    logic signed [WEIGHT_W-1:0] lo_clamp;
    logic signed [WEIGHT_W-1:0] hi_clamp;
    logic [BIN_W-1:0]           bin_of_event [NUM_EVENTS];
    logic signed [SUM_W-1:0]    bin_sum      [NUM_BINS];
    logic [SQ_W-1:0]            bin_sq       [NUM_BINS];
    bit                         touched      [NUM_BINS];
    bit                         pass_done;
    int                         mismatches = 0;

    assign o_fail_count = mismatches;

    // clamp, then saturating add of the weight and its truncated square
    task automatic add_to_bin(input logic [BIN_W-1:0] b,
                              input logic signed [WEIGHT_W-1:0] raw);
        logic signed [WEIGHT_W-1:0] w;
        logic signed [PROD_W-1:0]   prod;
        longint                     s;
        u64_t                       sq;
        u64_t                       q;
        w = raw;
        if (w < lo_clamp) w = lo_clamp;
        if (w > hi_clamp) w = hi_clamp;
        if (!touched[b]) begin
            bin_sum[b] = '0;
            bin_sq[b]  = '0;
            touched[b] = 1'b1;
        end
        s = longint'(bin_sum[b]) + longint'(w);
        if (s > SUM_MAX) s = SUM_MAX;
        else if (s < SUM_MIN) s = SUM_MIN;
        bin_sum[b] = s[SUM_W-1:0];
        prod = w * w;
        sq = u64_t'(prod) >> FRAC_W;
        q = u64_t'(bin_sq[b]) + sq;
        if (q > SQ_MAX) q = SQ_MAX;
        bin_sq[b] = q[SQ_W-1:0];
    endtask

    task automatic histogram_step(input logic [IN_DATA_W-1:0] data);
        logic [ACTION_W-1:0] act;
        logic [EVENT_W-1:0]  ev;
        logic [BIN_W-1:0]    bin;
        logic [WEIGHT_W-1:0] w;
        bin_readout_t        r;
        act = data[ACTION_W-1:0];
        ev  = data[ACTION_W +: EVENT_W];
        bin = data[ACTION_W+EVENT_W +: BIN_W];
        w   = data[ACTION_W+EVENT_W+BIN_W +: WEIGHT_W];
        case (act)
            ACT_MAP:    bin_of_event[ev] = bin;
            ACT_START: begin
                foreach (touched[i]) touched[i] = 1'b0;
                pass_done = 1'b0;
            end
            ACT_ADD:    add_to_bin(bin_of_event[ev], w);
            ACT_FINISH: pass_done = 1'b1;
            ACT_READ: begin
                r.sum    = touched[bin] ? bin_sum[bin] : '0;
                r.sum_sq = touched[bin] ? bin_sq[bin] : '0;
                r.ready  = pass_done;
                readout_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_readout(input logic [OUT_DATA_W-1:0] data);
        logic signed [SUM_W-1:0] got_sum;
        logic [SQ_W-1:0]         got_sq;
        logic                    got_ready;
        bin_readout_t            want;
        got_sum   = data[SUM_W-1:0];
        got_sq    = data[SUM_W +: SQ_W];
        got_ready = data[SUM_W+SQ_W];
        if (readout_q.size() == 0) begin
            $error("result word with no read outstanding");
            mismatches++;
        end else begin
            want = readout_q.pop_front();
            if (got_sum !== want.sum) begin
                $error("bin_sum: expected %0d, got %0d", want.sum, got_sum);
                mismatches++;
            end
            if (got_sq !== want.sum_sq) begin
                $error("bin_sum_squares: expected %0d, got %0d", want.sum_sq, got_sq);
                mismatches++;
            end
            if (got_ready !== want.ready) begin
                $error("sums_ready: expected %0b, got %0b", want.ready, got_ready);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lo_clamp  = LOWER_RESET;
            hi_clamp  = UPPER_RESET;
            pass_done = 1'b0;
            foreach (touched[i]) touched[i] = 1'b0;
            readout_q.delete();
        end else begin
            // results leave before the word taken at this edge can matter
            if (i_out_valid && i_out_ready) check_readout(i_out_data);
            if (i_in_valid && i_in_ready) histogram_step(i_in_data);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOWER_CLAMP) lo_clamp = i_cfg_data;
                else if (i_cfg_index == CFG_UPPER_CLAMP) hi_clamp = i_cfg_data;
            end
        end
        o_pending <= readout_q.size();
    end

endmodule

// ===== tb/tb_clamped_weighted_histogram_core.sv =====
module tb_clamped_weighted_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;
    import chwh_pkg::*;

    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 20000;   // idle cycles allowed, longer than a clearing sweep
    localparam int SETTLE_CYCLES = 8;       // lets an add run through map lookup, bin read and write-back
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 900;
    localparam int CALM_ITEMS    = 120;     // tail of the run with no idling
    localparam int HOT_BINS      = 8;
    localparam int BIG_ADDS      = 16;      // full-scale weights piled into one bin
    localparam int PAD_W         = IN_DATA_W - ACTION_W - EVENT_W - BIN_W - WEIGHT_W;
    localparam int ACT_CODE_MAX  = (1 << ACTION_W) - 1;

    localparam logic signed [WEIGHT_W-1:0] W_MIN = LOWER_RESET;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = UPPER_RESET;
    localparam logic signed [WEIGHT_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam int                         SMALL_SPAN = 4 * int'(Q_ONE);

    localparam logic [EVENT_W-1:0] EV_LOW  = '0;
    localparam logic [EVENT_W-1:0] EV_HIGH = '1;
    localparam logic [EVENT_W-1:0] EV_MID  = 16'h5A5A;
    localparam logic [BIN_W-1:0]   BIN_LOW  = '0;
    localparam logic [BIN_W-1:0]   BIN_HIGH = '1;
    localparam logic [BIN_W-1:0]   BIN_MID  = 10'h155;
    localparam logic [BIN_W-1:0]   BIN_HALF = 10'h200;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IW-1:0]      i_cfg_index;
    logic [WEIGHT_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;     // reads still owed a result word, a registered copy of the checker's count
    int stall_cycles = 0;

    // stimulus bookkeeping: which events have a bin, so no add hits an unwritten entry
    bit                         is_mapped [NUM_EVENTS];
    logic [BIN_W-1:0]           bin_of    [NUM_EVENTS];
    logic [EVENT_W-1:0]         mapped_events[$];
    logic [BIN_W-1:0]           hot_bins  [HOT_BINS];
    logic signed [WEIGHT_W-1:0] cur_lo = W_MIN;
    logic signed [WEIGHT_W-1:0] cur_hi = W_MAX;
    int                         gap_pct = 0;
    bit                         calm = 1'b0;
    int                         items_sent = 0;

    clamped_weighted_histogram_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    bin_sums_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: a run that stops moving words is a failure
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: ready in random runs, dropped for bursts unless the tail is calm
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    // one word per call, entered and left on a rising edge; valid stays high between
    // back-to-back words and only drops in this task when a gap is inserted; settle drops it too
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [EVENT_W-1:0] ev,
                             input logic [BIN_W-1:0] bin, input logic [WEIGHT_W-1:0] w);
        if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tdata  <= {{PAD_W{1'b0}}, w, bin, ev, act};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act <= ACT_READ) items_sent++;
    endtask

    // sender holds off until every read has its result and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic set_clamps(input logic signed [WEIGHT_W-1:0] lo,
                              input logic signed [WEIGHT_W-1:0] hi);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOWER_CLAMP;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_UPPER_CLAMP;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic map_event(input logic [EVENT_W-1:0] ev, input logic [BIN_W-1:0] bin);
        send_word(ACT_MAP, ev, bin, $urandom);
        if (!is_mapped[ev]) mapped_events.push_back(ev);
        is_mapped[ev] = 1'b1;
        bin_of[ev]    = bin;
    endtask

    task automatic add_weight(input logic [EVENT_W-1:0] ev, input logic [WEIGHT_W-1:0] w);
        send_word(ACT_ADD, ev, BIN_W'($urandom_range(0, NUM_BINS - 1)), w);
    endtask

    task automatic read_bin(input logic [BIN_W-1:0] bin);
        send_word(ACT_READ, EVENT_W'($urandom_range(0, NUM_EVENTS - 1)), bin, $urandom);
    endtask

    // start, finish and unknown codes, with the unused fields full of noise
    task automatic control(input logic [ACTION_W-1:0] act);
        send_word(act, EVENT_W'($urandom_range(0, NUM_EVENTS - 1)),
                  BIN_W'($urandom_range(0, NUM_BINS - 1)), $urandom);
    endtask

    function automatic logic [EVENT_W-1:0] pick_event();
        return mapped_events[$urandom_range(0, mapped_events.size() - 1)];
    endfunction

    // mostly a few hot bins so sums build up, otherwise anywhere
    function automatic logic [BIN_W-1:0] pick_bin();
        if ($urandom_range(0, 9) < 7) return hot_bins[$urandom_range(0, HOT_BINS - 1)];
        return BIN_W'($urandom_range(0, NUM_BINS - 1));
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        logic signed [WEIGHT_W-1:0] w;
        case ($urandom_range(0, 5))
            0, 1: w = $urandom;
            2: begin
                w = $urandom_range(0, SMALL_SPAN);
                if ($urandom_range(0, 1) != 0) w = -w;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0:       w = W_MAX;
                    1:       w = W_MIN;
                    2:       w = '0;
                    default: w = -32'sd1;
                endcase
            end
            4:       w = cur_lo + $signed($urandom_range(0, 2)) - 32'sd1;  // around the floor
            default: w = cur_hi + $signed($urandom_range(0, 2)) - 32'sd1;  // around the ceiling
        endcase
        return w;
    endfunction

    // a fresh clamp setting: full range, ordered, narrow, or crossed
    task automatic new_clamps();
        logic signed [WEIGHT_W-1:0] a;
        logic signed [WEIGHT_W-1:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 4))
            0: set_clamps(W_MIN, W_MAX);
            1: set_clamps((a < b) ? a : b, (a < b) ? b : a);
            2: set_clamps(-$signed($urandom_range(0, SMALL_SPAN)),
                          $signed($urandom_range(0, SMALL_SPAN)));
            3: set_clamps((a < b) ? b : a, (a < b) ? a : b);
            default: set_clamps(W_MAX, W_MIN);
        endcase
    endtask

    // a well-formed pass: maps, start, mostly weights, finish, then reads, mostly of bins in use
    task automatic run_pass();
        int n;
        if ($urandom_range(0, 3) == 0) new_clamps();
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 40;
        endcase
        n = $urandom_range(0, 4);
        repeat (n) map_event(EVENT_W'($urandom_range(0, NUM_EVENTS - 1)), pick_bin());
        control(ACT_START);
        n = $urandom_range(3, 30);
        repeat (n) begin
            case ($urandom_range(0, 15))
                0:       read_bin(bin_of[pick_event()]);      // sums_ready still low
                1:       map_event(pick_event(), pick_bin()); // remap within the pass
                default: add_weight(pick_event(), rand_weight());
            endcase
        end
        control(ACT_FINISH);
        n = $urandom_range(2, 6);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) read_bin(BIN_W'($urandom_range(0, NUM_BINS - 1)));
            else read_bin(bin_of[pick_event()]);
        end
    endtask

    // stray words: unknown codes, out-of-order controls, reads, maps and adds outside a pass
    task automatic noise_item();
        case ($urandom_range(0, 5))
            0:       control(ACTION_W'($urandom_range(int'(ACT_READ) + 1, ACT_CODE_MAX)));
            1:       control(ACT_FINISH);
            2:       control(ACT_START);
            3:       read_bin(BIN_W'($urandom_range(0, NUM_BINS - 1)));
            4:       add_weight(pick_event(), rand_weight());
            default: map_event(EVENT_W'($urandom_range(0, NUM_EVENTS - 1)), pick_bin());
        endcase
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_LOWER_CLAMP;
        i_cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme fields, every action, read before any pass
        set_clamps(W_MIN, W_MAX);
        map_event(EV_LOW, BIN_LOW);
        map_event(EV_HIGH, BIN_HIGH);
        map_event(EV_MID, BIN_MID);
        read_bin(BIN_LOW);
        control(ACT_START);
        add_weight(EV_LOW, W_MAX);
        add_weight(EV_LOW, W_MIN);
        add_weight(EV_HIGH, '0);
        add_weight(EV_HIGH, -32'sd1);
        add_weight(EV_MID, Q_ONE);
        read_bin(BIN_LOW);
        control(ACT_FINISH);
        read_bin(BIN_LOW);
        read_bin(BIN_HIGH);
        read_bin(BIN_MID);
        read_bin(BIN_HALF);                 // never touched in this pass
        for (int code = int'(ACT_READ) + 1; code <= ACT_CODE_MAX; code++) begin
            control(ACTION_W'(code));
        end
        add_weight(EV_MID, 32'sh1234_5678); // after finish, flag must stay set
        read_bin(BIN_MID);
        control(ACT_START);
        read_bin(BIN_HIGH);                 // cleared by the new pass
        control(ACT_FINISH);

        // crossed clamps: everything collapses onto the upper bound
        set_clamps(W_MAX, W_MIN);
        add_weight(EV_LOW, $urandom);
        read_bin(BIN_LOW);

        // large weights: full-scale adds pile up in one bin, then the bottom end
        set_clamps(W_MIN, W_MAX);
        control(ACT_START);
        repeat (BIG_ADDS) add_weight(EV_HIGH, W_MAX);
        read_bin(BIN_HIGH);
        add_weight(EV_HIGH, -Q_ONE);
        read_bin(BIN_HIGH);
        repeat (BIG_ADDS) add_weight(EV_LOW, W_MIN);
        control(ACT_FINISH);
        read_bin(BIN_LOW);
        read_bin(BIN_HIGH);

        // random part
        items_sent = 0;
        foreach (hot_bins[i]) hot_bins[i] = BIN_W'($urandom_range(0, NUM_BINS - 1));
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if ($urandom_range(0, 9) < 7) run_pass();
            else repeat ($urandom_range(1, 4)) noise_item();
        end

        // drain outstanding reads, then let the pipeline empty
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
